/* rtl/core/hwd_pkg.sv */
`default_nettype none
package hwd_pkg;

	// default build values
	localparam int STEPS_PER_CYCLE_DEF = 360;
	localparam int DUTY_BITS_DEF       = 10;
	localparam int SINE_FRAC_BITS_DEF  = 16;

	// field widths fixed by the interface
	localparam int ANGLE_W    = 9;
	localparam int BRIGHT_W   = 10;
	localparam int GAIN_W     = 9;
	localparam int IN_TDATA_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHTNESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RED       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_GREEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BLUE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUTPUT  = 3'd5;

	// register reset values
	localparam logic [BRIGHT_W-1:0] PEAK_LEVEL_RST     = 10'd32;
	localparam logic [BRIGHT_W-1:0] MIN_BRIGHTNESS_RST = 10'd8;
	localparam logic [GAIN_W-1:0]   GAIN_RED_RST       = 9'd256;
	localparam logic [GAIN_W-1:0]   GAIN_GREEN_RST     = 9'd230;
	localparam logic [GAIN_W-1:0]   GAIN_BLUE_RST      = 9'd179;
	localparam logic                INVERT_OUTPUT_RST  = 1'b1;

	// channel codes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef enum logic [1:0] {
		MUL_ENV,
		MUL_CG,
		MUL_MAIN,
		MUL_RECIP
	} mul_sel_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0] peak_level;
		logic [BRIGHT_W-1:0] min_brightness;
		logic [GAIN_W-1:0]   gain_red;
		logic [GAIN_W-1:0]   gain_green;
		logic [GAIN_W-1:0]   gain_blue;
		logic                invert_output;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       env_latch;
		logic       fix;
		logic       publish;
		logic [1:0] ch;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/hwd_ctrl.sv */
`default_nettype none
module hwd_ctrl import hwd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ENV,
		ST_CG,
		ST_MAIN,
		ST_RECIP,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= CH_RED;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_PREP;
				end
				ST_PREP: begin
					ch_q    <= CH_RED;
					state_q <= ST_ENV;
				end
				ST_ENV:   state_q <= ST_CG;
				ST_CG:    state_q <= ST_MAIN;
				ST_MAIN:  state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_FIX;
				ST_FIX: begin
					if (ch_q == CH_BLUE) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_CG;
					end
				end
				ST_DONE: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.ch        = ch_q;
		cmd.mul_sel   = MUL_ENV;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.prep      = (state_q == ST_PREP);
		cmd.env_latch = (state_q == ST_CG) && (ch_q == CH_RED);
		cmd.fix       = (state_q == ST_FIX);
		cmd.publish   = (state_q == ST_DONE) && stat.out_free;
		case (state_q)
			ST_ENV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ENV;
			end
			ST_CG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CG;
			end
			ST_MAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MAIN;
			end
			ST_RECIP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RECIP;
			end
			default: cmd.mul_en = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/hwd_datapath.sv */
`default_nettype none
module hwd_datapath import hwd_pkg::*; #(
	parameter int STEPS_PER_CYCLE = STEPS_PER_CYCLE_DEF,
	parameter int DUTY_BITS       = DUTY_BITS_DEF,
	parameter int SINE_FRAC_BITS  = SINE_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  cfg_t                       cfg,
	input  wire logic                  restart,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DUTY_BITS-1:0]       duty_red,
	output logic [DUTY_BITS-1:0]       duty_green,
	output logic [DUTY_BITS-1:0]       duty_blue,
	output logic [ANGLE_W-1:0]         hue_angle,
	output logic                       cycle_done
);

	localparam int E_W       = SINE_FRAC_BITS + 2;
	localparam int S_W       = SINE_FRAC_BITS + 1;
	localparam int ENV_W     = SINE_FRAC_BITS + BRIGHT_W + 1;
	localparam int A_W       = ENV_W;
	localparam int B_W       = 18;
	localparam int P_W       = A_W + B_W;
	localparam int CG_W      = 15;
	localparam int Y_W       = 17;
	localparam int Q_W       = 12;
	localparam int SAT_W     = 17;
	localparam int DIV_SH    = SINE_FRAC_BITS + 9;
	localparam int RECIP_SH  = 23;
	localparam int RECIP     = (1 << RECIP_SH) / 60;
	localparam int ROM_SH    = 16 - SINE_FRAC_BITS;
	localparam logic [ANGLE_W-1:0] LAST_ANGLE = ANGLE_W'(STEPS_PER_CYCLE - 1);
	localparam logic [SAT_W-1:0]   DUTY_MAX   = SAT_W'((1 << DUTY_BITS) - 1);
	localparam logic [5:0]         HUE_FULL   = 6'd60;

	// sin(d) for d = 0..90 degrees, scaled by 65536
	localparam logic [16:0] SINE_ROM [0:90] = '{
		17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
		17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
		17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
		17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
		17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
		17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
		17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
		17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
		17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
		17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
		17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
		17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
		17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
	};

	logic [ANGLE_W-1:0]   phase_q;
	logic [ANGLE_W-1:0]   angle_q;
	logic [2:0]           sector_q;
	logic [5:0]           k_q;
	logic [E_W-1:0]       e_q;
	logic [ENV_W-1:0]     env_q;
	logic [P_W-1:0]       mul_q;
	logic [Y_W-1:0]       y_q;
	logic [DUTY_BITS-1:0] duty_r_q, duty_g_q, duty_b_q;
	logic                 out_valid_q;

	// angle selection and wrap
	logic [ANGLE_W-1:0] angle_n;
	assign angle_n = restart ? '0 : phase_q;

	// sector, ramp and sine lookup
	logic [2:0]         sector_n;
	logic [ANGLE_W-1:0] base_n;
	logic [ANGLE_W-1:0] idx_w;
	logic               neg_n;
	logic [S_W-1:0]     sine_s;
	logic [E_W-1:0]     e_n;
	logic [E_W-1:0]     e_one;

	always_comb begin
		if (angle_q >= 9'd300)      sector_n = 3'd5;
		else if (angle_q >= 9'd240) sector_n = 3'd4;
		else if (angle_q >= 9'd180) sector_n = 3'd3;
		else if (angle_q >= 9'd120) sector_n = 3'd2;
		else if (angle_q >= 9'd60)  sector_n = 3'd1;
		else                        sector_n = 3'd0;
		case (sector_n)
			3'd0:    base_n = 9'd0;
			3'd1:    base_n = 9'd60;
			3'd2:    base_n = 9'd120;
			3'd3:    base_n = 9'd180;
			3'd4:    base_n = 9'd240;
			default: base_n = 9'd300;
		endcase
		if (angle_q <= 9'd90) begin
			idx_w = angle_q;
			neg_n = 1'b0;
		end else if (angle_q <= 9'd180) begin
			idx_w = 9'd180 - angle_q;
			neg_n = 1'b0;
		end else if (angle_q <= 9'd270) begin
			idx_w = angle_q - 9'd180;
			neg_n = 1'b1;
		end else begin
			idx_w = 9'd360 - angle_q;
			neg_n = 1'b1;
		end
		if (idx_w > 9'd90) idx_w = 9'd90;
		sine_s = S_W'(SINE_ROM[idx_w[6:0]] >> ROM_SH);
		e_one  = E_W'(1) << SINE_FRAC_BITS;
		e_n    = neg_n ? (e_one - E_W'(sine_s)) : (e_one + E_W'(sine_s));
	end

	// colour component and gain of the channel being worked
	logic [5:0]        k_fall;
	logic [5:0]        comp_r, comp_g, comp_b, comp_sel;
	logic [GAIN_W-1:0] gain_sel;

	always_comb begin
		k_fall = HUE_FULL - k_q;
		case (sector_q)
			3'd0: begin comp_r = HUE_FULL; comp_g = k_q;      comp_b = '0;       end
			3'd1: begin comp_r = k_fall;   comp_g = HUE_FULL; comp_b = '0;       end
			3'd2: begin comp_r = '0;       comp_g = HUE_FULL; comp_b = k_q;      end
			3'd3: begin comp_r = '0;       comp_g = k_fall;   comp_b = HUE_FULL; end
			3'd4: begin comp_r = k_q;      comp_g = '0;       comp_b = HUE_FULL; end
			default: begin comp_r = HUE_FULL; comp_g = '0;    comp_b = k_fall;   end
		endcase
		case (cmd.ch)
			CH_RED: begin
				comp_sel = comp_r;
				gain_sel = cfg.gain_red;
			end
			CH_GREEN: begin
				comp_sel = comp_g;
				gain_sel = cfg.gain_green;
			end
			default: begin
				comp_sel = comp_b;
				gain_sel = cfg.gain_blue;
			end
		endcase
	end

	// shared multiplier
	logic [Y_W-1:0] y_n;
	logic [A_W-1:0] mul_a;
	logic [B_W-1:0] mul_b;
	logic [P_W-1:0] mul_p;

	assign y_n = mul_q[DIV_SH +: Y_W];

	always_comb begin
		case (cmd.mul_sel)
			MUL_ENV: begin
				mul_a = A_W'(cfg.peak_level);
				mul_b = B_W'(e_q);
			end
			MUL_CG: begin
				mul_a = A_W'(comp_sel);
				mul_b = B_W'(gain_sel);
			end
			MUL_MAIN: begin
				mul_a = env_q;
				mul_b = B_W'(mul_q[CG_W-1:0]);
			end
			default: begin
				mul_a = A_W'(y_n);
				mul_b = B_W'(RECIP);
			end
		endcase
	end

	assign mul_p = P_W'(mul_a) * P_W'(mul_b);

	// envelope floor
	logic [ENV_W-1:0] env_raw, env_floor;
	assign env_raw   = mul_q[ENV_W-1:0];
	assign env_floor = ENV_W'(cfg.min_brightness) << (SINE_FRAC_BITS + 1);

	// divide by 60 from the reciprocal estimate, then saturate and, if invert_output is set, invert
	logic [Q_W-1:0]       q_est, q_fin;
	logic [Y_W-1:0]       q_times60, rem;
	logic [SAT_W-1:0]     q_sat;
	logic [DUTY_BITS-1:0] duty_n;

	always_comb begin
		q_est     = mul_q[RECIP_SH +: Q_W];
		q_times60 = Y_W'({q_est, 6'b0} - {2'b0, q_est, 2'b0});
		rem       = y_q - q_times60;
		q_fin     = q_est + Q_W'(rem >= Y_W'(60));
		q_sat     = (SAT_W'(q_fin) > DUTY_MAX) ? DUTY_MAX : SAT_W'(q_fin);
		if (cfg.invert_output) q_sat = DUTY_MAX - q_sat;
		duty_n    = DUTY_BITS'(q_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				phase_q <= (angle_n >= LAST_ANGLE) ? '0 : angle_n + 9'd1;
			end
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) angle_q <= angle_n;
		if (cmd.prep) begin
			sector_q <= sector_n;
			k_q      <= 6'(angle_q - base_n);
			e_q      <= e_n;
		end
		if (cmd.mul_en) mul_q <= mul_p;
		if (cmd.env_latch) env_q <= (env_raw < env_floor) ? env_floor : env_raw;
		if (cmd.mul_en && (cmd.mul_sel == MUL_RECIP)) y_q <= y_n;
		if (cmd.fix) begin
			case (cmd.ch)
				CH_RED:   duty_r_q <= duty_n;
				CH_GREEN: duty_g_q <= duty_n;
				default:  duty_b_q <= duty_n;
			endcase
		end
		if (cmd.publish) begin
			duty_red   <= duty_r_q;
			duty_green <= duty_g_q;
			duty_blue  <= duty_b_q;
			hue_angle  <= angle_q;
			cycle_done <= (angle_q == LAST_ANGLE);
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

/* rtl/core/rgb_hue_wheel_duty_generator_unit.sv */
`default_nettype none
// channel     | direction | handshake           | contents
// s_axis      | in        | s_tvalid / s_tready | tick, restart flag
// m_axis      | out       | m_tvalid / m_tready | three duties, hue angle, wheel end
// cfg         | in        | cfg_valid/cfg_ready | register index and write data
//
// s_tready drops once a tick is accepted and stays low until its result is
// published, so a tick is taken only after the previous one is through: a prep
// step, an envelope multiply, then four steps per channel (component times gain,
// envelope times that, reciprocal multiply for the divide by 60, fix-up and
// saturate) on one shared multiplier, and a publish step into the output register
// a new tick is taken while the previous result still sits in the output
// register; the publish step waits only if that register is still full
// reset clears the angle counter to 0, loads register defaults, empties the output
module rgb_hue_wheel_duty_generator_unit import hwd_pkg::*; #(
	parameter int STEPS_PER_CYCLE = STEPS_PER_CYCLE_DEF,
	parameter int DUTY_BITS       = DUTY_BITS_DEF,
	parameter int SINE_FRAC_BITS  = SINE_FRAC_BITS_DEF,
	localparam int OUT_FIELDS_W   = 3 * DUTY_BITS + ANGLE_W,
	localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // restart
	// output stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // duty_red, duty_green, duty_blue, hue_angle
	output logic                        m_tlast,   // cycle_done
	// configuration writes
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	logic [DUTY_BITS-1:0] duty_red, duty_green, duty_blue;
	logic [ANGLE_W-1:0]   hue_angle;

	// register file, values masked to register width, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_level     <= PEAK_LEVEL_RST;
			cfg_q.min_brightness <= MIN_BRIGHTNESS_RST;
			cfg_q.gain_red       <= GAIN_RED_RST;
			cfg_q.gain_green     <= GAIN_GREEN_RST;
			cfg_q.gain_blue      <= GAIN_BLUE_RST;
			cfg_q.invert_output  <= INVERT_OUTPUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PEAK_LEVEL:     cfg_q.peak_level     <= cfg_data[BRIGHT_W-1:0];
				CFG_MIN_BRIGHTNESS: cfg_q.min_brightness <= cfg_data[BRIGHT_W-1:0];
				CFG_GAIN_RED:       cfg_q.gain_red       <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_GREEN:     cfg_q.gain_green     <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_BLUE:      cfg_q.gain_blue      <= cfg_data[GAIN_W-1:0];
				CFG_INVERT_OUTPUT:  cfg_q.invert_output  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	hwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// angle counter, envelope, colour split and duty arithmetic
	hwd_datapath #(
		.STEPS_PER_CYCLE (STEPS_PER_CYCLE),
		.DUTY_BITS       (DUTY_BITS),
		.SINE_FRAC_BITS  (SINE_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg        (cfg_q),
		.restart    (s_tdata[0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.duty_red   (duty_red),
		.duty_green (duty_green),
		.duty_blue  (duty_blue),
		.hue_angle  (hue_angle),
		.cycle_done (m_tlast)
	);

	// pack fields lowest first, zero fill to whole bytes
	assign m_tdata = OUT_TDATA_W'({hue_angle, duty_blue, duty_green, duty_red});

endmodule
`default_nettype wire
